@@ rtl/scp_pkg.sv @@
// Shared constants, types and the key frequency ROM for the pitch snapper.
// Depends on nothing; every other file of the block imports it.
package scp_pkg;

   localparam int NUM_KEYS    = 88;
   localparam int FREQ_W      = 17;
   localparam int KEY_OUT_W   = 7;
   localparam int ROM_DEPTH   = 128;
   localparam int ROM_IDX_W   = $clog2(ROM_DEPTH);
   // Key counter must hold NUM_KEYS plus the largest step and still index the ROM.
   localparam int KEY_W       = ($clog2(NUM_KEYS + 3) > ROM_IDX_W) ?
                                $clog2(NUM_KEYS + 3) : ROM_IDX_W;
   localparam int ROOT_W      = 4;
   localparam int MODE_W      = 2;
   localparam int STEP_W      = 2;
   localparam int SCALE_LEN   = 7;
   localparam int SIDX_W      = $clog2(SCALE_LEN);
   localparam int OCTAVE      = 12;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 4;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_ROOT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_MODE = CSR_IDX_W'(1);

   // Scale modes; the unused code behaves as major
   localparam logic [MODE_W-1:0] MODE_MAJOR     = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_MINOR     = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_CHROMATIC = MODE_W'(2);

   localparam logic [ROOT_W-1:0] ROOT_RESET = ROOT_W'(1);
   localparam logic [MODE_W-1:0] MODE_RESET = MODE_MAJOR;

   localparam logic [STEP_W-1:0] MAJOR_STEPS [SCALE_LEN] = '{
      2'd2, 2'd2, 2'd1, 2'd2, 2'd2, 2'd2, 2'd1 };
   localparam logic [STEP_W-1:0] MINOR_STEPS [SCALE_LEN] = '{
      2'd2, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd2 };

   // Equal-tempered key frequencies, unsigned Q13.4 Hz, key 1 (A0) first,
   // rounded half up and saturated at the field maximum.
   localparam logic [FREQ_W-1:0] ROM_TABLE [ROM_DEPTH] = '{
      17'd440,    17'd466,    17'd494,    17'd523,    17'd554,    17'd587,
      17'd622,    17'd659,    17'd698,    17'd740,    17'd784,    17'd831,
      17'd880,    17'd932,    17'd988,    17'd1047,   17'd1109,   17'd1175,
      17'd1245,   17'd1319,   17'd1397,   17'd1480,   17'd1568,   17'd1661,
      17'd1760,   17'd1865,   17'd1976,   17'd2093,   17'd2217,   17'd2349,
      17'd2489,   17'd2637,   17'd2794,   17'd2960,   17'd3136,   17'd3322,
      17'd3520,   17'd3729,   17'd3951,   17'd4186,   17'd4435,   17'd4699,
      17'd4978,   17'd5274,   17'd5588,   17'd5920,   17'd6272,   17'd6645,
      17'd7040,   17'd7459,   17'd7902,   17'd8372,   17'd8870,   17'd9397,
      17'd9956,   17'd10548,  17'd11175,  17'd11840,  17'd12544,  17'd13290,
      17'd14080,  17'd14917,  17'd15804,  17'd16744,  17'd17740,  17'd18795,
      17'd19912,  17'd21096,  17'd22351,  17'd23680,  17'd25088,  17'd26580,
      17'd28160,  17'd29834,  17'd31609,  17'd33488,  17'd35479,  17'd37589,
      17'd39824,  17'd42192,  17'd44701,  17'd47359,  17'd50175,  17'd53159,
      17'd56320,  17'd59669,  17'd63217,  17'd66976,  17'd70959,  17'd75178,
      17'd79649,  17'd84385,  17'd89402,  17'd94719,  17'd100351, 17'd106318,
      17'd112640, 17'd119338, 17'd126434, 17'd131071, 17'd131071, 17'd131071,
      17'd131071, 17'd131071, 17'd131071, 17'd131071, 17'd131071, 17'd131071,
      17'd131071, 17'd131071, 17'd131071, 17'd131071, 17'd131071, 17'd131071,
      17'd131071, 17'd131071, 17'd131071, 17'd131071, 17'd131071, 17'd131071,
      17'd131071, 17'd131071, 17'd131071, 17'd131071, 17'd131071, 17'd131071,
      17'd131071, 17'd131071 };

   localparam logic [FREQ_W-1:0] TOP_FREQ = ROM_TABLE[NUM_KEYS-1];

   typedef struct packed {
      logic start;     // load a new request
      logic step;      // examine the current candidate key
      logic load_out;  // move the chosen key into the output register
   } scp_cmd_type;

   typedef struct packed {
      logic done;      // current candidate settles the answer
   } scp_stat_type;

   // ROM frequency of a key; the key wraps modulo the ROM depth
   function automatic logic [FREQ_W-1:0] rom_freq(input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] key_m1;
      key_m1 = key - KEY_W'(1);
      return ROM_TABLE[key_m1[ROM_IDX_W-1:0]];
   endfunction

   // First scale key: the root wrapped into 1..12
   function automatic logic [KEY_W-1:0] root_key(input logic [ROOT_W-1:0] root);
      logic [4:0] r;
      r = {1'b0, root} + 5'd11;
      if (r >= 5'(2 * OCTAVE)) begin
         r = r - 5'(2 * OCTAVE);
      end else if (r >= 5'(OCTAVE)) begin
         r = r - 5'(OCTAVE);
      end
      return KEY_W'(r) + KEY_W'(1);
   endfunction

   function automatic logic [STEP_W-1:0] scale_step(input logic [MODE_W-1:0] mode,
                                                    input logic [SIDX_W-1:0] idx);
      if (mode == MODE_MINOR) begin
         return MINOR_STEPS[idx];
      end
      return MAJOR_STEPS[idx];
   endfunction

endpackage

@@ rtl/scp_if.sv @@
// Valid/ready channel interfaces of the pitch snapper: request, response, CSR.
// Depends on scp_pkg for the payload widths.
interface scp_req_if import scp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FREQ_W-1:0] frequency;
   modport source (output valid, frequency, input ready);
   modport sink   (input valid, frequency, output ready);
endinterface

interface scp_rsp_if import scp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KEY_OUT_W-1:0] key_number;
   logic [FREQ_W-1:0]    key_frequency;
   modport source (output valid, key_number, key_frequency, input ready);
   modport sink   (input valid, key_number, key_frequency, output ready);
endinterface

interface scp_csr_if import scp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/scp_datapath.sv @@
// Datapath of the pitch snapper: candidate key walk, ROM compare, result registers.
// Depends on scp_pkg; driven by scp_controller through scp_cmd_type.
module scp_datapath import scp_pkg::*; (
   input  logic                  clock,
   input  logic [FREQ_W-1:0]     req_frequency,
   input  logic [ROOT_W-1:0]     scale_root,
   input  logic [MODE_W-1:0]     scale_mode,
   input  scp_cmd_type           cmd,
   output scp_stat_type          stat,
   output logic [KEY_OUT_W-1:0]  rsp_key_number,
   output logic [FREQ_W-1:0]     rsp_key_frequency
);

   logic [FREQ_W-1:0]    freq_ff,      freq_in;
   logic                 above_ff,     above_in;
   logic [KEY_W-1:0]     key_ff,       key_in;
   logic [SIDX_W-1:0]    sidx_ff,      sidx_in;
   logic [KEY_W-1:0]     prev_ff,      prev_in;
   logic [FREQ_W-1:0]    prev_f_ff,    prev_f_in;
   logic                 have_prev_ff, have_prev_in;
   logic [KEY_W-1:0]     res_key_ff,   res_key_in;
   logic [KEY_OUT_W-1:0] out_key_ff,   out_key_in;
   logic [FREQ_W-1:0]    out_freq_ff,  out_freq_in;

   logic                 chromatic;
   logic [FREQ_W-1:0]    cur_f;
   logic [FREQ_W-1:0]    up_gap;
   logic [FREQ_W-1:0]    dn_gap;
   logic                 done;
   logic [KEY_W-1:0]     pick;
   logic [KEY_W-1:0]     next_key;

   assign chromatic = (scale_mode == MODE_CHROMATIC);
   assign cur_f     = rom_freq(key_ff);
   assign up_gap    = cur_f - freq_ff;
   assign dn_gap    = freq_ff - prev_f_ff;
   assign next_key  = key_ff + (chromatic ? KEY_W'(1) : KEY_W'(scale_step(scale_mode, sidx_ff)));

   // Decide on the current candidate
   always_comb begin
      done = 1'b1;
      pick = key_ff;
      priority if (above_ff) begin
         pick = KEY_W'(NUM_KEYS);
      end else if (key_ff > KEY_W'(NUM_KEYS)) begin
         pick = prev_ff;
      end else if (freq_ff == cur_f) begin
         pick = key_ff;
      end else if (freq_ff < cur_f) begin
         pick = (have_prev_ff && (up_gap > dn_gap)) ? prev_ff : key_ff;
      end else begin
         done = 1'b0;
      end
   end

   assign stat.done = done;

   always_comb begin
      freq_in      = freq_ff;
      above_in     = above_ff;
      key_in       = key_ff;
      sidx_in      = sidx_ff;
      prev_in      = prev_ff;
      prev_f_in    = prev_f_ff;
      have_prev_in = have_prev_ff;
      res_key_in   = res_key_ff;
      out_key_in   = out_key_ff;
      out_freq_in  = out_freq_ff;
      if (cmd.start) begin
         freq_in      = req_frequency;
         above_in     = (req_frequency > TOP_FREQ);
         key_in       = chromatic ? KEY_W'(1) : root_key(scale_root);
         sidx_in      = '0;
         have_prev_in = 1'b0;
      end
      if (cmd.step) begin
         if (done) begin
            res_key_in = pick;
         end else begin
            // advance to the next candidate
            prev_in      = key_ff;
            prev_f_in    = cur_f;
            have_prev_in = 1'b1;
            key_in       = next_key;
            sidx_in      = (sidx_ff == SIDX_W'(SCALE_LEN - 1)) ? '0 : sidx_ff + SIDX_W'(1);
         end
      end
      if (cmd.load_out) begin
         out_key_in  = res_key_ff[KEY_OUT_W-1:0];
         out_freq_in = rom_freq(res_key_ff);
      end
   end

   always_ff @(posedge clock) begin
      freq_ff      <= freq_in;
      above_ff     <= above_in;
      key_ff       <= key_in;
      sidx_ff      <= sidx_in;
      prev_ff      <= prev_in;
      prev_f_ff    <= prev_f_in;
      have_prev_ff <= have_prev_in;
      res_key_ff   <= res_key_in;
      out_key_ff   <= out_key_in;
      out_freq_ff  <= out_freq_in;
   end

   assign rsp_key_number    = out_key_ff;
   assign rsp_key_frequency = out_freq_ff;

endmodule

@@ rtl/scp_controller.sv @@
// Controller of the pitch snapper: request intake, walk sequencing, response valid.
// Depends on scp_pkg; commands scp_datapath through scp_cmd_type.
module scp_controller import scp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  scp_stat_type stat,
   output scp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (stat.done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_start_walks: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> state_ff == ST_WALK)
      else $error("request accepted without entering the walk");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten before it was taken");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded response not presented");

   a_hold_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && stat.done) |=> state_ff == ST_HOLD)
      else $error("walk finished without holding the result");

endmodule

@@ rtl/scale_constrained_pitch_snap.sv @@
// Top level of the scale-constrained pitch snapper: CSRs, controller, datapath.
// Depends on scp_pkg, scp_if.sv, scp_controller and scp_datapath.
//
// Use of the block:
//  - req_port carries a measured frequency (unsigned Q13.4 Hz). A request is
//    taken when valid and ready are both high; ready is high only while no
//    request is being walked or waiting for the output register.
//  - rsp_port returns the nearest allowed key number (1 is A0) and that key's
//    ROM frequency. Exactly one response per request, in order.
//  - csr_port writes scale_root (index 0) and scale_mode (index 1: major,
//    minor, chromatic; the spare code acts as major). Always ready; write
//    only while no request is outstanding.
//  - From acceptance, the candidate walk examines one key of the ROM per
//    cycle until one settles the answer, then the result is loaded into the
//    output register once that is free; a frequency above the top key is
//    settled by the first candidate. A new request is taken the cycle after
//    the previous one is loaded into the output register; no new request is
//    taken while one is being walked or held.
//  - When the receiver stalls the response holds in the output register; one
//    further request may be accepted and walked, then holds until the
//    output register frees.
//  - Synchronous reset drops any request in flight, clears the response
//    valid and restores scale_root to 1 and scale_mode to major.
module scale_constrained_pitch_snap import scp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   scp_req_if.sink   req_port,
   scp_rsp_if.source rsp_port,
   scp_csr_if.sink   csr_port
);

   logic [ROOT_W-1:0] scale_root_ff, scale_root_in;
   logic [MODE_W-1:0] scale_mode_ff, scale_mode_in;
   scp_cmd_type       cmd;
   scp_stat_type      stat;
   logic              csr_write;

   // Configuration registers: always ready, ignore indexes beyond the list
   assign csr_port.ready = 1'b1;
   assign csr_write      = csr_port.valid && csr_port.ready;

   always_comb begin
      scale_root_in = scale_root_ff;
      scale_mode_in = scale_mode_ff;
      if (csr_write) begin
         unique case (csr_port.index)
            CSR_SCALE_ROOT: scale_root_in = csr_port.data[ROOT_W-1:0];
            CSR_SCALE_MODE: scale_mode_in = csr_port.data[MODE_W-1:0];
            default: begin
               scale_root_in = scale_root_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_root_ff <= ROOT_RESET;
         scale_mode_ff <= MODE_RESET;
      end else begin
         scale_root_ff <= scale_root_in;
         scale_mode_ff <= scale_mode_in;
      end
   end

   // Sequence the walk and own the response handshake
   scp_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the request, walk the candidate keys and register the response
   scp_datapath u_datapath (
      .clock             (clock),
      .req_frequency     (req_port.frequency),
      .scale_root        (scale_root_ff),
      .scale_mode        (scale_mode_ff),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_key_number    (rsp_port.key_number),
      .rsp_key_frequency (rsp_port.key_frequency)
   );

endmodule
